// ----- sv/grs_pkg.sv -----
// ----------------------------------------------------------------------------
// GRIB record splitter package
// Shared constants and types for the record splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

  localparam int unsigned WinDepth = 16;
  localparam int unsigned FillW    = $clog2(WinDepth + 1);
  localparam int unsigned IdxW     = $clog2(WinDepth);
  localparam int unsigned LenW     = 64;
  localparam int unsigned EdPos    = 7;
  localparam int unsigned Ed1Need  = 8;

  localparam logic [7:0] MarkG = 8'h47;
  localparam logic [7:0] MarkR = 8'h52;
  localparam logic [7:0] MarkI = 8'h49;
  localparam logic [7:0] MarkB = 8'h42;

  localparam logic [7:0] EdOne = 8'd1;
  localparam logic [7:0] EdTwo = 8'd2;

  localparam logic [1:0] DestDrop = 2'd0;
  localparam logic [1:0] DestEd1  = 2'd1;
  localparam logic [1:0] DestEd2  = 2'd2;

  typedef logic [WinDepth-1:0][7:0] window_t;

  typedef struct packed {
    logic            found;
    logic [1:0]      dest;
    logic            zero_len;
    logic [LenW-1:0] len_m1;
  } head_t;

endpackage

`default_nettype wire

// ----- sv/grs_in_if.sv -----
// ----------------------------------------------------------------------------
// Record splitter input channel
// Valid/ready channel that carries one stream byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface grs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ----- sv/grs_out_if.sv -----
// ----------------------------------------------------------------------------
// Record splitter output channel
// Valid/ready channel that carries one tagged byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface grs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] destination;
  logic       record_start;
  logic       last;

  modport source (output valid, output out_byte, output destination,
                  output record_start, output last, input ready);
  modport sink   (input valid, input out_byte, input destination,
                  input record_start, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/grs_head_decode.sv -----
// ----------------------------------------------------------------------------
// Record header decoder
// Checks the window head for a GRIB marker with a known edition and extracts
// the record length.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_head_decode (
  input  grs_pkg::window_t         win_i,
  input  logic [grs_pkg::FillW-1:0] fill_i,
  output grs_pkg::head_t           head_o
);
  import grs_pkg::*;

  logic            magic_ok;
  logic            is_ed1;
  logic            is_ed2;
  logic [LenW-1:0] len;

  assign magic_ok = (win_i[0] == MarkG) && (win_i[1] == MarkR) &&
                    (win_i[2] == MarkI) && (win_i[3] == MarkB) &&
                    (fill_i >= FillW'(Ed1Need));
  assign is_ed1   = magic_ok && (win_i[EdPos] == EdOne);
  assign is_ed2   = magic_ok && (win_i[EdPos] == EdTwo) && (fill_i == FillW'(WinDepth));

  always_comb begin
    if (is_ed1) begin
      len = {40'd0, win_i[4], win_i[5], win_i[6]};
    end else begin
      len = {win_i[8], win_i[9], win_i[10], win_i[11],
             win_i[12], win_i[13], win_i[14], win_i[15]};
    end
  end

  assign head_o.found    = is_ed1 || is_ed2;
  assign head_o.dest     = is_ed1 ? DestEd1 : DestEd2;
  assign head_o.zero_len = (len == '0);
  assign head_o.len_m1   = len - LenW'(1);

endmodule

`default_nettype wire

// ----- sv/grib_record_splitter.sv -----
// ----------------------------------------------------------------------------
// GRIB record splitter
// Tags each byte of a byte stream with its destination: drop, edition-1
// stream or edition-2 stream.
// ----------------------------------------------------------------------------
// Bytes enter on in_i and leave in the same order on out_o, each word tagged
// with a destination, a record start flag and an end-of-stream flag.
// Every byte passes through a 16-byte look-ahead window, so a byte leaves
// only after the 15 bytes that follow it have been accepted, or when a word
// with end_of_stream set has been accepted.
// A byte that leaves the window is registered and presented on out_o in the
// next cycle. Throughput is one byte per cycle while out_o is not stalled;
// header decode and the 64-bit length counter both finish within that cycle.
// After an end-of-stream word the window drains at one byte per cycle while
// out_o is not stalled, and in_i.ready stays low until the final word, marked
// with last, has left the window. All record state then returns to reset.
// When out_o is stalled the output register holds its word; in_i keeps
// accepting until the window is full.
// Reset clears the window count and all record state.
// ----------------------------------------------------------------------------
`default_nettype none

module grib_record_splitter (
  input  logic             clk_i,
  input  logic             rst_ni,
  grs_in_if.sink           in_i,
  grs_out_if.source        out_o
);
  import grs_pkg::*;

  window_t          win_q, win_d, win_sh;
  logic [FillW-1:0] fill_q, fill_d, fill_sh;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [1:0]       cur_q, cur_d;
  logic             in_rec_q, in_rec_d;
  logic             halted_q, halted_d;
  logic             flush_q, flush_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic [1:0]       out_dest_q, dest;
  logic             out_start_q, start;
  logic             out_last_q;

  head_t            head;
  logic             out_free;
  logic             emit;
  logic             last_emit;
  logic             accept;

  grs_head_decode u_head (
    .win_i  (win_q),
    .fill_i (fill_q),
    .head_o (head)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign emit      = out_free &&
                     ((fill_q == FillW'(WinDepth)) || (flush_q && (fill_q != '0)));
  assign last_emit = flush_q && (fill_q == FillW'(1));
  assign in_i.ready = !flush_q && ((fill_q < FillW'(WinDepth)) || emit);
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_sh[i] = emit ? win_q[i+1] : win_q[i];
    end
    win_sh[WinDepth-1] = emit ? 8'h00 : win_q[WinDepth-1];
    fill_sh = fill_q - FillW'(emit);

    win_d  = win_sh;
    fill_d = fill_sh;
    if (accept) begin
      win_d[fill_sh[IdxW-1:0]] = in_i.data_byte;
      fill_d = fill_sh + FillW'(1);
    end
  end

  always_comb begin
    rem_d    = rem_q;
    cur_d    = cur_q;
    in_rec_d = in_rec_q;
    halted_d = halted_q;
    flush_d  = flush_q;
    dest     = DestDrop;
    start    = 1'b0;

    if (emit) begin
      priority if (halted_q) begin
        dest = DestDrop;
      end else if (in_rec_q) begin
        dest  = cur_q;
        rem_d = rem_q - LenW'(1);
        if (rem_q == LenW'(1)) begin
          in_rec_d = 1'b0;
        end
      end else if (head.found) begin
        if (head.zero_len) begin
          halted_d = 1'b1;
          dest     = DestDrop;
        end else begin
          cur_d    = head.dest;
          rem_d    = head.len_m1;
          in_rec_d = (head.len_m1 != '0);
          start    = 1'b1;
          dest     = head.dest;
        end
      end else begin
        dest = cur_q;
      end

      if (last_emit) begin
        rem_d    = '0;
        cur_d    = DestDrop;
        in_rec_d = 1'b0;
        halted_d = 1'b0;
        flush_d  = 1'b0;
      end
    end

    if (accept && in_i.end_of_stream) begin
      flush_d = 1'b1;
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rem_q       <= '0;
      cur_q       <= DestDrop;
      in_rec_q    <= 1'b0;
      halted_q    <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      cur_q       <= cur_d;
      in_rec_q    <= in_rec_d;
      halted_q    <= halted_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (emit) begin
      out_byte_q  <= win_q[0];
      out_dest_q  <= dest;
      out_start_q <= start;
      out_last_q  <= last_emit;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.destination  = out_dest_q;
  assign out_o.record_start = out_start_q;
  assign out_o.last         = out_last_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WinDepth))
    else $error("window count exceeds depth");

  a_no_input_in_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !in_i.ready)
    else $error("input accepted while draining");

  a_start_routed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.record_start) |-> (out_o.destination != DestDrop))
    else $error("record start tagged as drop");

  a_halt_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !in_rec_q)
    else $error("halted while a record is open");

  a_drain_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_emit) |=> (!flush_q && !in_rec_q && !halted_q && (fill_q == '0)))
    else $error("state not cleared after final word");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// GRIB record splitter testbench
// Sends byte streams that mix well-formed edition-1 and edition-2 records with
// noise, unknown editions, zero lengths, truncated headers and records that
// run past the end of the stream. A scoreboard predicts the destination,
// record start and last flag of every word that leaves the block and compares
// them in order. Both sides idle at random, and once the output is held off
// long enough that the block has to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import grs_pkg::*;

  localparam int unsigned RandomItems = 120;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned MaxGap      = 14;
  localparam logic [7:0]  OddEdition  = 8'h07;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] dest;
    logic       start;
    logic       last;
  } routed_word_t;

  class route_scoreboard;
    logic [7:0]      win [WinDepth];
    int unsigned     fill;
    logic [LenW-1:0] remaining;
    logic [1:0]      cur_dest;
    bit              in_rec;
    bit              halted;
    routed_word_t    expected [$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     records;

    function new();
      mismatches = 0;
      checked    = 0;
      records    = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[k]) win[k] = '0;
      fill      = 0;
      remaining = '0;
      cur_dest  = DestDrop;
      in_rec    = 1'b0;
      halted    = 1'b0;
    endfunction

    function void pop_head(bit is_last);
      logic [7:0]      data;
      logic [1:0]      dest;
      logic            start;
      logic [LenW-1:0] len;
      bit              found;
      data  = win[0];
      dest  = cur_dest;
      start = 1'b0;
      if (halted) begin
        dest = DestDrop;
      end else if (in_rec) begin
        remaining = remaining - 1;
        if (remaining == 0) in_rec = 1'b0;
      end else begin
        found = fill >= Ed1Need && win[0] == MarkG && win[1] == MarkR &&
                win[2] == MarkI && win[3] == MarkB &&
                (win[EdPos] == EdOne || (win[EdPos] == EdTwo && fill >= WinDepth));
        if (found) begin
          len = '0;
          if (win[EdPos] == EdOne) begin
            len = {40'd0, win[4], win[5], win[6]};
          end else begin
            for (int k = EdPos + 1; k < WinDepth; k++) len = {len[LenW-9:0], win[k]};
          end
          if (len == 0) begin
            halted = 1'b1;
            dest   = DestDrop;
          end else begin
            cur_dest  = win[EdPos][1:0];
            remaining = len - 1;
            in_rec    = remaining != 0;
            start     = 1'b1;
            dest      = cur_dest;
            records++;
          end
        end
      end
      for (int k = 0; k < WinDepth - 1; k++) win[k] = win[k+1];
      win[WinDepth-1] = '0;
      if (fill > 0) fill--;
      expected.push_back('{data, dest, start, is_last});
    endfunction

    function void note_byte(logic [7:0] data, logic eos);
      if (fill >= WinDepth) fill = WinDepth - 1;
      win[fill] = data;
      fill++;
      if (eos) begin
        while (fill > 0) pop_head(fill == 1);
        restart();
      end else if (fill == WinDepth) begin
        pop_head(1'b0);
      end
    endfunction

    function void check_word(logic [7:0] data, logic [1:0] dest, logic start, logic last);
      routed_word_t want;
      checked++;
      if (expected.size() == 0) begin
        $error("unexpected word: out_byte %02h destination %0d", data, dest);
        mismatches++;
        return;
      end
      want = expected.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        mismatches++;
      end
      if (dest !== want.dest) begin
        $error("destination: expected %0d, got %0d", want.dest, dest);
        mismatches++;
      end
      if (start !== want.start) begin
        $error("record_start: expected %0b, got %0b", want.start, start);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_request;

  route_scoreboard board = new();

  grs_in_if  in_ch ();
  grs_out_if out_ch ();

  grib_record_splitter uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_record(ref logic [7:0] s[$], output bit open_ended);
    int unsigned     kind;
    int unsigned     hdr;
    logic [LenW-1:0] len;
    logic [7:0]      ed;
    kind = $urandom_range(0, 19);
    len  = $urandom_range(1, 40);
    if (kind < 9) begin
      ed = EdOne;
    end else if (kind < 16) begin
      ed = EdTwo;
    end else if (kind < 18) begin
      do ed = $urandom_range(0, 255); while (ed == EdOne || ed == EdTwo);
    end else begin
      ed = $urandom_range(0, 1) ? EdOne : EdTwo;
    end
    if (kind == 18) len = '0;
    open_ended = kind == 19;
    if (open_ended) len = {$urandom, $urandom};
    s.push_back(MarkG);
    s.push_back(MarkR);
    s.push_back(MarkI);
    s.push_back(MarkB);
    if (ed == EdOne) begin
      s.push_back(len[23:16]);
      s.push_back(len[15:8]);
      s.push_back(len[7:0]);
      s.push_back(ed);
      hdr = 8;
    end else begin
      repeat (3) s.push_back(8'($urandom));
      s.push_back(ed);
      for (int k = 7; k >= 0; k--) s.push_back(len[8*k +: 8]);
      hdr = 16;
    end
    if (open_ended) begin
      repeat ($urandom_range(0, 20)) s.push_back(8'($urandom));
    end else begin
      for (int k = hdr; k < len; k++) s.push_back(8'($urandom));
      repeat ($urandom_range(0, 4)) s.push_back(8'($urandom));
    end
  endfunction

  task automatic send_stream(input logic [7:0] s[$], input bit quiet);
    int unsigned gap;
    foreach (s[k]) begin
      gap = quiet ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid         <= 1'b1;
      in_ch.data_byte     <= s[k];
      in_ch.end_of_stream <= (k == s.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      board.note_byte(s[k], k == s.size() - 1);
    end
  endtask

  initial begin
    logic [7:0]  s [$];
    logic [7:0]  head [$];
    bit          open_ended;
    bit          quiet;
    int unsigned target;
    int unsigned cut;
    int unsigned sent_random;
    int unsigned streams;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_stream <= 1'b0;
    rst_n               <= 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unknown edition, a short edition-1 record, then a zero length that halts.
    s = '{8'hFF,
          MarkG, MarkR, MarkI, MarkB, 8'h00, 8'h00, 8'h00, OddEdition,
          MarkG, MarkR, MarkI, MarkB, 8'h00, 8'h00, 8'h02, EdOne,
          MarkG, MarkR, MarkI, MarkB, 8'h00, 8'h00, 8'h00, EdOne};
    send_stream(s, 1'b0);
    // Edition-2 record that is longer than the stream.
    s = '{MarkG, MarkR, MarkI, MarkB, 8'h12, 8'h34, 8'h56, EdTwo,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
    send_stream(s, 1'b1);
    streams     = 2;
    sent_random = 0;

    while (sent_random < RandomItems) begin
      quiet  = $urandom_range(0, 3) == 0;
      target = $urandom_range(1, 48);
      if (streams == 3) begin
        in_ch.valid <= 1'b0;
        while (board.expected.size() != 0) @(posedge clk);
        quiet        = 1'b1;
        target       = 48;
        hold_request = 1'b1;
      end
      s.delete();
      open_ended = 1'b0;
      repeat ($urandom_range(0, 5)) s.push_back(8'($urandom));
      while (s.size() < target && !open_ended) add_record(s, open_ended);
      if (!open_ended && $urandom_range(0, 3) == 0) begin
        head.delete();
        add_record(head, open_ended);
        cut = $urandom_range(4, 15);
        if (cut > head.size()) cut = head.size();
        for (int k = 0; k < cut; k++) s.push_back(head[k]);
      end
      send_stream(s, quiet);
      sent_random += s.size();
      streams++;
    end
    in_ch.valid <= 1'b0;

    while (board.expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d streams; %0d words checked, %0d records recognized.",
             streams, board.checked, board.records);
    $display("Covered noise, unknown editions, zero lengths, truncated headers %s",
             "and a long output stall.");
    if (board.mismatches == 0) begin
      $display("[grib_record_splitter] OK");
    end else begin
      $display("[grib_record_splitter] ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int unsigned words;
    bit          quiet;
    words = 0;
    quiet = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MaxGap);
      if (hold_request) begin
        hold_request = 1'b0;
        gap          = HoldCycles;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_word(out_ch.out_byte, out_ch.destination, out_ch.record_start,
                       out_ch.last);
      words++;
      if (words % 24 == 0) quiet = $urandom_range(0, 2) == 0;
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end while (idle < StallLimit);
    $display("Timeout: no word moved for %0d cycles.", StallLimit);
    $display("[grib_record_splitter] ERROR");
    $finish;
  end

endmodule
